### hw/rtl/ltpd_pkg.sv
// Shared types, state codes and the per-type length table of the packet deframer.
package ltpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;

  localparam logic [LEN_W-1:0] LEN_VARIABLE = 16'h0000;
  localparam logic [LEN_W-1:0] LEN_UNKNOWN  = 16'hFFFF;
  localparam logic [LEN_W-1:0] LEN_SINGLE   = 16'h0001;
  localparam logic [LEN_W-1:0] LEN_MIN_VAR  = 16'h0003;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_LEN_HI = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_BODY   = 5'b01000,
    PH_HALT   = 5'b10000
  } phase_t;

  // One result transaction as it leaves the framing logic.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] packet_type;
    logic [LEN_W-1:0]  byte_offset;
    logic              packet_first;
    logic              packet_last;
    logic              framing_error;
  } result_t;

  // Total packet length per type byte; zero is variable, all ones is unknown.
  localparam logic [LEN_W-1:0] LEN_TABLE [256] = '{
    16'h0068, 16'h0005, 16'h0007, 16'h0000, 16'h0002, 16'h0005, 16'h0005, 16'h0007,
    16'h000e, 16'h0005, 16'h000b, 16'h010a, 16'h0000, 16'h0003, 16'h0000, 16'h003d,
    16'h00d7, 16'h0000, 16'h0000, 16'h000a, 16'h0006, 16'h0009, 16'h0001, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0025, 16'h0000, 16'h0005, 16'h0004, 16'h0008,
    16'h0013, 16'h0008, 16'h0003, 16'h001a, 16'h0007, 16'h0014, 16'h0005, 16'h0002,
    16'h0005, 16'h0001, 16'h0005, 16'h0002, 16'h0002, 16'h0011, 16'h000f, 16'h000a,
    16'h0005, 16'h0001, 16'h0002, 16'h0002, 16'h000a, 16'h028d, 16'h0000, 16'h0008,
    16'h0007, 16'h0009, 16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h0025, 16'h0000,
    16'h00c9, 16'h0000, 16'h0000, 16'h0229, 16'h02c9, 16'h0005, 16'h0000, 16'h000b,
    16'h0049, 16'h005d, 16'h0005, 16'h0009, 16'h0000, 16'h0000, 16'h0006, 16'h0002,
    16'h0000, 16'h0000, 16'h0000, 16'h0002, 16'h000c, 16'h0001, 16'h000b, 16'h006e,
    16'h006a, 16'h0000, 16'h0000, 16'h0004, 16'h0002, 16'h0049, 16'h0000, 16'h0031,
    16'h0005, 16'h0009, 16'h000f, 16'h000d, 16'h0001, 16'h0004, 16'h0000, 16'h0015,
    16'h0000, 16'h0000, 16'h0003, 16'h0009, 16'h0013, 16'h0003, 16'h000e, 16'h0000,
    16'h001c, 16'h0000, 16'h0005, 16'h0002, 16'h0000, 16'h0023, 16'h0010, 16'h0011,
    16'h0000, 16'h0009, 16'h0000, 16'h0002, 16'h0000, 16'h000d, 16'h0002, 16'h0000,
    16'h003e, 16'h0000, 16'h0002, 16'h0027, 16'h0045, 16'h0002, 16'h0000, 16'h0000,
    16'h0042, 16'h0000, 16'h0000, 16'h0000, 16'h000b, 16'h0000, 16'h0000, 16'h0000,
    16'h0013, 16'h0041, 16'h0000, 16'h0063, 16'h0000, 16'h0009, 16'h0000, 16'h0002,
    16'h0000, 16'h001a, 16'h0000, 16'h0102, 16'h0135, 16'h0033, 16'h0000, 16'h0000,
    16'h0003, 16'h0009, 16'h0009, 16'h0009, 16'h0095, 16'h0000, 16'h0000, 16'h0004,
    16'h0000, 16'h0000, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h000d,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0040, 16'h0009, 16'h0000,
    16'h0000, 16'h0003, 16'h0006, 16'h0009, 16'h0003, 16'h0000, 16'h0000, 16'h0000,
    16'h0024, 16'h0000, 16'h0000, 16'h0000, 16'h0006, 16'h00cb, 16'h0001, 16'h0031,
    16'h0002, 16'h0006, 16'h0006, 16'h0007, 16'h0000, 16'h0001, 16'h0000, 16'h004e,
    16'h0000, 16'h0002, 16'h0019, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h010C, 16'hFFFF, 16'hFFFF, 16'h0009, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF
  };

endpackage

### hw/rtl/ltpd_len_rom.sv
// Length table ROM with a registered read port.
module ltpd_len_rom
  import ltpd_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [BYTE_W-1:0] rd_addr,
  output logic [LEN_W-1:0]  rd_data
);

  logic [LEN_W-1:0] rd_data_r;

  // Read data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= LEN_TABLE[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/ltpd_frame_fsm.sv
// Framing state machine and output register of the packet deframer.
module ltpd_frame_fsm
  import ltpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_valid,
  input  logic [BYTE_W-1:0] step_byte,
  input  logic [LEN_W-1:0]  step_len,
  output logic              step_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] len_hi_r, len_hi_nxt;
  logic [LEN_W-1:0]  exp_len_r, exp_len_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic              err_r, err_nxt;
  logic              res_valid_r, res_valid_nxt;
  result_t           res_r, res_nxt;
  logic              step_fire;
  logic [LEN_W-1:0]  total;
  logic [LEN_W:0]    pos_inc;

  assign step_ready = !res_valid_r || res_ready;
  assign step_fire  = step_valid && step_ready;
  assign total      = {len_hi_r, step_byte};
  assign pos_inc    = {1'b0, pos_r} + {{LEN_W{1'b0}}, 1'b1};

  always_comb begin
    phase_nxt   = phase_r;
    type_nxt    = type_r;
    len_hi_nxt  = len_hi_r;
    exp_len_nxt = exp_len_r;
    pos_nxt     = pos_r;
    err_nxt     = err_r;
    res_nxt     = res_r;
    res_valid_nxt = res_valid_r && !res_ready;

    if (step_fire) begin
      res_nxt.byte_offset  = '0;
      res_nxt.packet_first = 1'b0;
      res_nxt.packet_last  = 1'b0;
      unique case (phase_r)
        PH_IDLE: begin
          type_nxt = step_byte;
          res_nxt.packet_first = 1'b1;
          if (step_len == LEN_UNKNOWN) begin
            res_nxt.packet_last = 1'b1;
            err_nxt   = 1'b1;
            phase_nxt = PH_HALT;
          end else if (step_len == LEN_VARIABLE) begin
            pos_nxt   = LEN_W'(1);
            phase_nxt = PH_LEN_HI;
          end else if (step_len == LEN_SINGLE) begin
            res_nxt.packet_last = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            exp_len_nxt = step_len;
            pos_nxt     = LEN_W'(1);
            phase_nxt   = PH_BODY;
          end
        end
        PH_LEN_HI: begin
          len_hi_nxt = step_byte;
          res_nxt.byte_offset = LEN_W'(1);
          pos_nxt   = LEN_W'(2);
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          res_nxt.byte_offset = LEN_W'(2);
          if (total < LEN_MIN_VAR) begin
            res_nxt.packet_last = 1'b1;
            err_nxt   = 1'b1;
            phase_nxt = PH_HALT;
          end else begin
            exp_len_nxt = total;
            if (total == LEN_MIN_VAR) begin
              res_nxt.packet_last = 1'b1;
              phase_nxt = PH_IDLE;
            end else begin
              pos_nxt   = LEN_W'(3);
              phase_nxt = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          res_nxt.byte_offset = pos_r;
          if (pos_inc >= {1'b0, exp_len_r}) begin
            res_nxt.packet_last = 1'b1;
            phase_nxt = PH_IDLE;
          end else begin
            pos_nxt = pos_inc[LEN_W-1:0];
          end
        end
        default: begin
          phase_nxt = PH_HALT;
        end
      endcase
      res_nxt.data_byte     = step_byte;
      res_nxt.packet_type   = type_nxt;
      res_nxt.framing_error = err_nxt;
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      type_r      <= '0;
      len_hi_r    <= '0;
      exp_len_r   <= '0;
      pos_r       <= '0;
      err_r       <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      type_r      <= type_nxt;
      len_hi_r    <= len_hi_nxt;
      exp_len_r   <= exp_len_nxt;
      pos_r       <= pos_nxt;
      err_r       <= err_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

### hw/rtl/length_table_packet_deframer_core.sv
// Top level of the length table packet deframer: input stage, table ROM and framing logic.
//
//   Channel  Direction  tdata                                      tuser / tlast
//   in_      slave      [7:0] stream_byte                          -
//   out_     master     [7:0] data_byte, [15:8] packet_type,       tuser[0] packet_first,
//                       [31:16] byte_offset                        tuser[1] framing_error,
//                                                                  tlast packet_last
//
// One byte per cycle sustained while out_tready is high; a byte passes through the input
// stage register and then the output register. The table ROM is read as a byte is taken,
// and the framing step runs on the registered table entry, so each step sees the state
// the previous byte left. Synchronous active-low reset clears all framing state and the
// sticky error. The input stage buffers one byte while the output is stalled.
module length_table_packet_deframer_core
  import ltpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [15:8] packet_type, [31:16] byte_offset
  output logic [1:0]  out_tuser,  // [0] packet_first, [1] framing_error
  output logic        out_tlast   // packet_last
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              in_fire;
  logic              step_ready;
  logic [LEN_W-1:0]  step_len;
  result_t           res;

  assign in_tready    = !s1_valid_r || step_ready;
  assign in_fire      = in_tvalid && in_tready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !step_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
    end
  end

  ltpd_len_rom u_len_rom (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_tdata),
    .rd_data (step_len)
  );

  ltpd_frame_fsm u_frame_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (s1_valid_r),
    .step_byte  (s1_byte_r),
    .step_len   (step_len),
    .step_ready (step_ready),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {res.byte_offset, res.packet_type, res.data_byte};
  assign out_tuser = {res.framing_error, res.packet_first};
  assign out_tlast = res.packet_last;

endmodule
